/* rtl/core/pfd_pkg.sv */
// Package for the playfair digraph encryptor: letter codes, square geometry,
// opcode and state types, and small index helpers. No dependencies.
`default_nettype none

package pfd_pkg;

    // field widths
    localparam int OPCODE_W = 3;
    localparam int LETTER_W = 5;
    localparam int PLACE_W  = 6;
    localparam int COORD_W  = 3;

    // square geometry
    localparam int SIDE    = 5;
    localparam int CELLS   = 25;
    localparam int LETTERS = 26;

    localparam logic [LETTER_W-1:0] CODE_I = LETTER_W'(8);
    localparam logic [LETTER_W-1:0] CODE_J = LETTER_W'(9);
    localparam logic [LETTER_W-1:0] CODE_X = LETTER_W'(23);

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR_KEY = 3'd0,
        OP_KEY_LETTER = 3'd1,
        OP_KEY_DONE   = 3'd2,
        OP_PLAIN      = 3'd3,
        OP_END_MSG    = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_PLACE,
        ST_SQUARE
    } t_state;

    // J is folded onto I before any lookup
    function automatic logic [LETTER_W-1:0] fold_j(input logic [LETTER_W-1:0] c);
        return (c == CODE_J) ? CODE_I : c;
    endfunction

    // cyclic step of a row or column index
    function automatic logic [COORD_W-1:0] step_side(input logic [COORD_W-1:0] v);
        return (v == COORD_W'(SIDE - 1)) ? '0 : v + COORD_W'(1);
    endfunction

    // square address row*5+col
    function automatic logic [LETTER_W-1:0] cell_addr(input logic [COORD_W-1:0] row,
                                                      input logic [COORD_W-1:0] col);
        logic [LETTER_W-1:0] r5;
        r5 = {row[LETTER_W-3:0], 2'b00} + LETTER_W'(row);
        return r5 + LETTER_W'(col);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/pfd_in_if.sv */
// Input channel of the playfair encryptor: valid/ready plus opcode and letter.
// Depends on pfd_pkg for field widths.
`default_nettype none

interface pfd_in_if;
    logic                          valid;
    logic                          ready;
    logic [pfd_pkg::OPCODE_W-1:0]  opcode;
    logic [pfd_pkg::LETTER_W-1:0]  letter;

    modport source (output valid, output opcode, output letter, input ready);
    modport sink   (input valid, input opcode, input letter, output ready);
endinterface

`default_nettype wire

/* rtl/core/pfd_out_if.sv */
// Output channel of the playfair encryptor: valid/ready plus the cipher pair.
// Depends on pfd_pkg for field widths.
`default_nettype none

interface pfd_out_if;
    logic                          valid;
    logic                          ready;
    logic [pfd_pkg::LETTER_W-1:0]  cipher_first;
    logic [pfd_pkg::LETTER_W-1:0]  cipher_second;

    modport source (output valid, output cipher_first, output cipher_second, input ready);
    modport sink   (input valid, input cipher_first, input cipher_second, output ready);
endinterface

`default_nettype wire

/* rtl/core/pfd_ram.sv */
// Generic RAM: one write port, two registered read ports sharing a read enable.
// No dependencies.
`default_nettype none

module pfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output      logic [WIDTH-1:0] o_rdata_a,
    output      logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered reads, held while the enable is low
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= mem[i_raddr_a];
            o_rdata_b <= mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/playfair_digraph_encrypt.sv */
// Playfair digraph encryptor, letters coded 0..25.
// Input channel i_in carries a word of opcode and letter: clear key, key letter,
// key done, plaintext letter, end of message. Output channel o_out carries one
// word per enciphered pair (cipher_first, cipher_second).
// A clear key or key letter word is handled in the idle state. A key done word walks the
// alphabet one letter per cycle through the square memory write port, so the
// input is held off until the walk is done.
// A plaintext or end-of-message word that completes a pair starts two dependent
// lookups: letter place memory, then square memory, one registered read each.
// The result is loaded into the output register from the square stage, and the
// input is held off through the place and square stages; other plaintext words
// are taken in the idle state.
// The output register lets a new word in while a result waits; if the receiver
// still stalls when the next pair is ready, the block waits in the square stage.
// Reset (i_rst_n low, synchronous) empties the key square and drops any pending
// letter; the memories themselves are not cleared, their contents are only read
// once a complete square has been rewritten.
// Depends on pfd_pkg, pfd_in_if, pfd_out_if and pfd_ram.
`default_nettype none

module playfair_digraph_encrypt (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    pfd_in_if.sink    i_in,
    pfd_out_if.source o_out
);

    localparam int LW = pfd_pkg::LETTER_W;
    localparam int CW = pfd_pkg::COORD_W;
    localparam int PW = pfd_pkg::PLACE_W;

    pfd_pkg::t_state r_state, n_state;

    logic [pfd_pkg::LETTERS-1:0] r_used, n_used;
    logic [LW-1:0]               r_fill, n_fill;
    logic [CW-1:0]               r_row, n_row;
    logic [CW-1:0]               r_col, n_col;
    logic [LW-1:0]               r_held, n_held;
    logic                        r_held_v, n_held_v;
    logic [LW-1:0]               r_k, n_k;
    logic                        r_out_v, n_out_v;
    logic [LW-1:0]               r_out_first, n_out_first;
    logic [LW-1:0]               r_out_second, n_out_second;

    logic          in_fire;
    logic          full;
    logic          letter_ok;
    logic          place_en;
    logic          place_go;
    logic [LW-1:0] place_letter;
    logic          pair_go;
    logic [LW-1:0] pair_a;
    logic [LW-1:0] pair_b;
    logic          out_free;

    logic [PW-1:0] place_rd_a, place_rd_b;
    logic [LW-1:0] sq_rd_a, sq_rd_b;
    logic          sq_re;
    logic [LW-1:0] sq_addr_a, sq_addr_b;
    logic [CW-1:0] r1, c1, r2, c2;
    logic [CW-1:0] r1n, c1n, r2n, c2n;

    assign full      = (r_fill == LW'(pfd_pkg::CELLS));
    assign letter_ok = (i_in.letter < LW'(pfd_pkg::LETTERS));
    assign in_fire   = i_in.valid && i_in.ready;
    assign out_free  = !r_out_v || o_out.ready;

    assign i_in.ready          = (r_state == pfd_pkg::ST_IDLE);
    assign o_out.valid         = r_out_v;
    assign o_out.cipher_first  = r_out_first;
    assign o_out.cipher_second = r_out_second;

    // letter places and square letters, both written by key placement
    pfd_ram #(.WIDTH(PW), .DEPTH(pfd_pkg::LETTERS)) u_place_ram (
        .i_clk     (i_clk),
        .i_we      (place_go),
        .i_waddr   (place_letter),
        .i_wdata   ({r_row, r_col}),
        .i_re      (pair_go),
        .i_raddr_a (pair_a),
        .i_raddr_b (pair_b),
        .o_rdata_a (place_rd_a),
        .o_rdata_b (place_rd_b)
    );

    pfd_ram #(.WIDTH(LW), .DEPTH(pfd_pkg::CELLS)) u_square_ram (
        .i_clk     (i_clk),
        .i_we      (place_go),
        .i_waddr   (r_fill),
        .i_wdata   (place_letter),
        .i_re      (sq_re),
        .i_raddr_a (sq_addr_a),
        .i_raddr_b (sq_addr_b),
        .o_rdata_a (sq_rd_a),
        .o_rdata_b (sq_rd_b)
    );

    // playfair rules on the looked-up places
    always_comb begin
        r1  = place_rd_a[PW-1:CW];
        c1  = place_rd_a[CW-1:0];
        r2  = place_rd_b[PW-1:CW];
        c2  = place_rd_b[CW-1:0];
        r1n = r1;
        c1n = c1;
        r2n = r2;
        c2n = c2;
        priority if (r1 == r2) begin
            c1n = pfd_pkg::step_side(c1);
            c2n = pfd_pkg::step_side(c2);
        end else if (c1 == c2) begin
            r1n = pfd_pkg::step_side(r1);
            r2n = pfd_pkg::step_side(r2);
        end else begin
            c1n = c2;
            c2n = c1;
        end
        sq_addr_a = pfd_pkg::cell_addr(r1n, c1n);
        sq_addr_b = pfd_pkg::cell_addr(r2n, c2n);
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pfd_pkg::ST_IDLE;
            r_used   <= '0;
            r_fill   <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_held   <= '0;
            r_held_v <= 1'b0;
            r_k      <= '0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_fill   <= n_fill;
            r_row    <= n_row;
            r_col    <= n_col;
            r_held   <= n_held;
            r_held_v <= n_held_v;
            r_k      <= n_k;
            r_out_v  <= n_out_v;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_first  <= n_out_first;
        r_out_second <= n_out_second;
    end

    // next state, placement and pairing
    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_fill       = r_fill;
        n_row        = r_row;
        n_col        = r_col;
        n_held       = r_held;
        n_held_v     = r_held_v;
        n_k          = r_k;
        n_out_v      = r_out_v;
        n_out_first  = r_out_first;
        n_out_second = r_out_second;
        place_en     = 1'b0;
        place_letter = pfd_pkg::fold_j(i_in.letter);
        pair_go      = 1'b0;
        pair_a       = pfd_pkg::fold_j(r_held);
        pair_b       = pfd_pkg::CODE_X;
        sq_re        = 1'b0;

        // taken result leaves the output register
        if (r_out_v && o_out.ready) begin
            n_out_v = 1'b0;
        end

        unique case (r_state)
            pfd_pkg::ST_IDLE: begin
                if (in_fire) begin
                    unique case (i_in.opcode)
                        pfd_pkg::OP_CLEAR_KEY: begin
                            n_used   = '0;
                            n_fill   = '0;
                            n_row    = '0;
                            n_col    = '0;
                            n_held   = '0;
                            n_held_v = 1'b0;
                        end
                        pfd_pkg::OP_KEY_LETTER: begin
                            place_en = letter_ok;
                        end
                        pfd_pkg::OP_KEY_DONE: begin
                            n_k     = '0;
                            n_state = pfd_pkg::ST_FILL;
                        end
                        pfd_pkg::OP_PLAIN: begin
                            if (letter_ok && full) begin
                                n_held = i_in.letter;
                                if (!r_held_v) begin
                                    n_held_v = 1'b1;
                                end else begin
                                    // equal pair splits with X, letter stays held
                                    n_held_v = (i_in.letter == r_held);
                                    pair_b   = (i_in.letter == r_held) ? pfd_pkg::CODE_X
                                                                       : pfd_pkg::fold_j(i_in.letter);
                                    pair_go  = 1'b1;
                                    n_state  = pfd_pkg::ST_PLACE;
                                end
                            end
                        end
                        pfd_pkg::OP_END_MSG: begin
                            if (r_held_v && full) begin
                                n_held_v = 1'b0;
                                pair_go  = 1'b1;
                                n_state  = pfd_pkg::ST_PLACE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            pfd_pkg::ST_FILL: begin
                // walk the alphabet, skipping J
                place_letter = r_k;
                place_en     = (r_k != pfd_pkg::CODE_J);
                n_k          = r_k + LW'(1);
                if (r_k == LW'(pfd_pkg::LETTERS - 1)) begin
                    n_state = pfd_pkg::ST_IDLE;
                end
            end
            pfd_pkg::ST_PLACE: begin
                sq_re   = 1'b1;
                n_state = pfd_pkg::ST_SQUARE;
            end
            pfd_pkg::ST_SQUARE: begin
                if (out_free) begin
                    n_out_v      = 1'b1;
                    n_out_first  = sq_rd_a;
                    n_out_second = sq_rd_b;
                    n_state      = pfd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pfd_pkg::ST_IDLE;
            end
        endcase

        // place one letter at the next free cell
        place_go = place_en && !full && !r_used[place_letter];
        if (place_go) begin
            n_used[place_letter] = 1'b1;
            n_fill               = r_fill + LW'(1);
            n_col                = pfd_pkg::step_side(r_col);
            if (r_col == CW'(pfd_pkg::SIDE - 1)) begin
                n_row = r_row + CW'(1);
            end
        end
    end

    // used letters and filled cells move together
    a_used_matches_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_used) == int'(r_fill))
        else $error("used letter count differs from fill count");

    // lookups only run on a complete square
    a_lookup_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfd_pkg::ST_PLACE) |-> full)
        else $error("pair lookup on an incomplete square");

    // a new result comes only from the square stage
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> ($past(r_state) == pfd_pkg::ST_SQUARE))
        else $error("result loaded outside the square stage");

    // the fill walk never shrinks the square
    a_fill_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfd_pkg::ST_FILL) |=> (r_fill >= $past(r_fill)))
        else $error("fill count dropped during the fill walk");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for playfair_digraph_encrypt: a directed table and then random
// key/message phases, scored against a behavioral Playfair square kept in the bench.
// Depends on pfd_pkg, pfd_in_if, pfd_out_if and the encryptor RTL.

module tb_top;
    import pfd_pkg::*;

    localparam int RAND_WORDS   = 500;
    localparam int QUIET_TAIL   = 60;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_SHOWN    = 10;

    // opcodes the block has no meaning for
    localparam logic [OPCODE_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
    } t_cipher_pair;

    // how a table row is scored: by the square model, typed no-result, typed pair
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_PAIR} t_row_check;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [LETTER_W-1:0] ltr;
        t_row_check          chk;
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
    } t_stim_row;

    // key "J" gives the square I A B C D / E F G H K / L M N O P / Q R S T U / V W X Y Z
    localparam int DIR_ROWS = 29;
    t_stim_row dir_rows [DIR_ROWS] = '{
        '{OP_PLAIN,      5'd0,   CHK_NONE,  5'd0,  5'd0 },  // square not built yet
        '{OP_END_MSG,    5'd0,   CHK_NONE,  5'd0,  5'd0 },
        '{OP_KEY_LETTER, CODE_J, CHK_NONE,  5'd0,  5'd0 },  // J lands as I
        '{OP_KEY_LETTER, CODE_J, CHK_NONE,  5'd0,  5'd0 },  // already placed
        '{OP_KEY_LETTER, 5'd31,  CHK_NONE,  5'd0,  5'd0 },  // letter out of range
        '{OP_SPARE_7,    5'd31,  CHK_NONE,  5'd0,  5'd0 },
        '{OP_KEY_DONE,   5'd0,   CHK_NONE,  5'd0,  5'd0 },
        '{OP_KEY_DONE,   5'd0,   CHK_NONE,  5'd0,  5'd0 },  // square already full
        '{OP_KEY_LETTER, 5'd0,   CHK_NONE,  5'd0,  5'd0 },  // key letter after full
        '{OP_PLAIN,      5'd25,  CHK_NONE,  5'd0,  5'd0 },
        '{OP_PLAIN,      5'd0,   CHK_PAIR,  5'd22, 5'd3 },  // Z,A rectangle -> W,D
        '{OP_PLAIN,      CODE_X, CHK_NONE,  5'd0,  5'd0 },
        '{OP_PLAIN,      CODE_X, CHK_PAIR,  5'd24, 5'd24},  // X,X split -> Y,Y
        '{OP_END_MSG,    5'd0,   CHK_PAIR,  5'd24, 5'd24},  // lone X padded
        '{OP_END_MSG,    5'd0,   CHK_NONE,  5'd0,  5'd0 },  // nothing pending
        '{OP_PLAIN,      CODE_I, CHK_NONE,  5'd0,  5'd0 },
        '{OP_PLAIN,      CODE_J, CHK_MODEL, 5'd0,  5'd0 },  // I,J not split, same cell
        '{OP_PLAIN,      5'd30,  CHK_NONE,  5'd0,  5'd0 },
        '{OP_SPARE_5,    5'd3,   CHK_NONE,  5'd0,  5'd0 },
        '{OP_PLAIN,      5'd0,   CHK_NONE,  5'd0,  5'd0 },
        '{OP_PLAIN,      5'd5,   CHK_MODEL, 5'd0,  5'd0 },  // A,F same column
        '{OP_PLAIN,      5'd3,   CHK_NONE,  5'd0,  5'd0 },
        '{OP_PLAIN,      CODE_I, CHK_MODEL, 5'd0,  5'd0 },  // D,I same row wrap
        '{OP_PLAIN,      5'd1,   CHK_NONE,  5'd0,  5'd0 },
        '{OP_CLEAR_KEY,  5'd31,  CHK_NONE,  5'd0,  5'd0 },  // drops pending B
        '{OP_END_MSG,    5'd0,   CHK_NONE,  5'd0,  5'd0 },
        '{OP_KEY_DONE,   5'd0,   CHK_NONE,  5'd0,  5'd0 },  // plain alphabet square
        '{OP_PLAIN,      5'd2,   CHK_NONE,  5'd0,  5'd0 },
        '{OP_END_MSG,    5'd31,  CHK_MODEL, 5'd0,  5'd0 }
    };

    logic clk;
    logic rst_n;

    pfd_in_if  in_ch ();
    pfd_out_if out_ch ();

    playfair_digraph_encrypt dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // square model state
    logic [LETTER_W-1:0] sq_cell [CELLS];
    int                  row_of  [LETTERS];
    int                  col_of  [LETTERS];
    bit                  placed  [LETTERS];
    int                  n_filled;
    logic [LETTER_W-1:0] pend_letter;
    bit                  pend_valid;

    t_cipher_pair expect_q [$];
    int           err_cnt;
    int           sent_words;
    int           cycles;
    bit           idle_en;
    bit           hold_req;

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void note_error(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_SHOWN) $display("%0t: %s", $time, msg);
    endfunction

    // expected pair goes to the back of the queue
    function automatic void queue_pair(input t_cipher_pair p);
        expect_q.insert(expect_q.size(), p);
    endfunction

    // next free cell takes the letter unless it is already in the square
    function automatic void place_in_square(input logic [LETTER_W-1:0] c);
        if (n_filled >= CELLS || c >= LETTERS || placed[c]) return;
        sq_cell[n_filled] = c;
        row_of[c] = n_filled / SIDE;
        col_of[c] = n_filled % SIDE;
        placed[c] = 1'b1;
        n_filled++;
    endfunction

    // row, column and rectangle rules on one pair
    function automatic void pair_cipher(input logic [LETTER_W-1:0] a_in,
                                        input logic [LETTER_W-1:0] b_in,
                                        output logic [LETTER_W-1:0] f,
                                        output logic [LETTER_W-1:0] s);
        logic [LETTER_W-1:0] a;
        logic [LETTER_W-1:0] b;
        int r1, c1, r2, c2, t;
        a = (a_in == CODE_J) ? CODE_I : a_in;
        b = (b_in == CODE_J) ? CODE_I : b_in;
        r1 = row_of[a];
        c1 = col_of[a];
        r2 = row_of[b];
        c2 = col_of[b];
        if (r1 == r2) begin
            c1 = (c1 + 1) % SIDE;
            c2 = (c2 + 1) % SIDE;
        end else if (c1 == c2) begin
            r1 = (r1 + 1) % SIDE;
            r2 = (r2 + 1) % SIDE;
        end else begin
            t  = c1;
            c1 = c2;
            c2 = t;
        end
        f = sq_cell[r1 * SIDE + c1];
        s = sq_cell[r2 * SIDE + c2];
    endfunction

    // apply one word to the square model; returns 1 when a cipher pair comes out
    function automatic bit encrypt_word(input logic [OPCODE_W-1:0] op,
                                        input logic [LETTER_W-1:0] ltr,
                                        output logic [LETTER_W-1:0] f,
                                        output logic [LETTER_W-1:0] s);
        logic [LETTER_W-1:0] c;
        bit has;
        c    = ltr;
        has  = 1'b0;
        f    = '0;
        s    = '0;
        case (op)
            OP_CLEAR_KEY: begin
                placed      = '{default: 1'b0};
                n_filled    = 0;
                pend_valid  = 1'b0;
                pend_letter = '0;
            end
            OP_KEY_LETTER: begin
                if (c < LETTERS) begin
                    if (c == CODE_J) c = CODE_I;
                    place_in_square(c);
                end
            end
            OP_KEY_DONE: begin
                for (int k = 0; k < LETTERS; k++)
                    if (k != CODE_J) place_in_square(LETTER_W'(k));
            end
            OP_PLAIN: begin
                if (c < LETTERS && n_filled == CELLS) begin
                    if (!pend_valid) begin
                        pend_letter = c;
                        pend_valid  = 1'b1;
                    end else if (c == pend_letter) begin
                        // doubled letter: X goes between, the letter stays pending
                        pair_cipher(pend_letter, CODE_X, f, s);
                        has = 1'b1;
                    end else begin
                        pair_cipher(pend_letter, c, f, s);
                        pend_valid = 1'b0;
                        has        = 1'b1;
                    end
                end
            end
            OP_END_MSG: begin
                if (pend_valid && n_filled == CELLS) begin
                    pair_cipher(pend_letter, CODE_X, f, s);
                    pend_valid = 1'b0;
                    has        = 1'b1;
                end
            end
            default: ;
        endcase
        return has;
    endfunction

    // mostly legal letters, now and then an out-of-range code
    function automatic logic [LETTER_W-1:0] rand_letter();
        if ($urandom_range(0, 15) == 0) return LETTER_W'($urandom_range(26, 31));
        return LETTER_W'($urandom_range(0, 25));
    endfunction

    // offer one word, wait for the handshake, then log what it should produce
    task automatic send_word(input logic [OPCODE_W-1:0] op,
                             input logic [LETTER_W-1:0] ltr,
                             input t_row_check chk = CHK_MODEL,
                             input logic [LETTER_W-1:0] tf = '0,
                             input logic [LETTER_W-1:0] ts = '0);
        t_cipher_pair got;
        t_cipher_pair typed;
        bit has;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= op;
        in_ch.letter <= ltr;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        has = encrypt_word(op, ltr, got.first, got.second);
        sent_words++;
        if (chk == CHK_PAIR) begin
            if (!has || got.first != tf || got.second != ts)
                note_error($sformatf("table op %0d letter %0d: typed %0d,%0d model %0d,%0d",
                                     op, ltr, tf, ts, got.first, got.second));
            typed.first  = tf;
            typed.second = ts;
            queue_pair(typed);
        end else if (chk == CHK_NONE) begin
            if (has)
                note_error($sformatf("table op %0d letter %0d: typed no pair, model gives one",
                                     op, ltr));
        end else if (has) begin
            queue_pair(got);
        end
        @(negedge clk);
    endtask

    // output scoreboard
    always @(posedge clk) begin : out_check
        t_cipher_pair want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expect_q.size() == 0) begin
                note_error($sformatf("unexpected pair %0d,%0d",
                                     out_ch.cipher_first, out_ch.cipher_second));
            end else begin
                want = expect_q.pop_front();
                if (out_ch.cipher_first !== want.first || out_ch.cipher_second !== want.second)
                    note_error($sformatf("pair mismatch: expected %0d,%0d got %0d,%0d",
                                         want.first, want.second,
                                         out_ch.cipher_first, out_ch.cipher_second));
            end
        end
    end

    // run limit
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin : sink_side
        int stall_left;
        stall_left   = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && idle_en && $urandom_range(0, 6) == 0) begin
                stall_left = $urandom_range(1, 13);
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // stimulus
    initial begin : source_side
        int phase_no;
        int n;
        int pick;
        bit broken;
        logic [LETTER_W-1:0] last_ltr;

        err_cnt      = 0;
        sent_words   = 0;
        cycles       = 0;
        idle_en      = 1'b1;
        hold_req     = 1'b0;
        placed       = '{default: 1'b0};
        n_filled     = 0;
        pend_letter  = '0;
        pend_valid   = 1'b0;
        rst_n        <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.opcode <= OP_CLEAR_KEY;
        in_ch.letter <= '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[r])
            send_word(dir_rows[r].op, dir_rows[r].ltr, dir_rows[r].chk,
                      dir_rows[r].first, dir_rows[r].second);

        // random key and message phases
        sent_words = 0;
        phase_no   = 0;
        while (sent_words < RAND_WORDS) begin
            if (sent_words >= RAND_WORDS - QUIET_TAIL) idle_en = 1'b0;
            pick   = $urandom_range(0, 9);
            broken = (pick == 8);
            send_word(OP_CLEAR_KEY, LETTER_W'($urandom_range(0, 31)));
            // long keys overflow the square now and then
            n = (pick == 9) ? $urandom_range(20, 32) : $urandom_range(0, 10);
            for (int k = 0; k < n; k++) send_word(OP_KEY_LETTER, rand_letter());
            // plaintext before the square is complete is dropped
            if (broken) begin
                for (int k = 0; k < 3; k++) send_word(OP_PLAIN, rand_letter());
                send_word(OP_END_MSG, LETTER_W'($urandom_range(0, 31)));
            end
            send_word(OP_KEY_DONE, LETTER_W'($urandom_range(0, 31)));
            if (phase_no == 3) begin
                // long receiver hold-off while a message keeps coming
                in_ch.valid <= 1'b0;
                @(posedge clk);
                hold_req = 1'b1;
                @(negedge clk);
                n = 60;
            end else begin
                n = $urandom_range(4, 40);
            end
            last_ltr = rand_letter();
            for (int k = 0; k < n; k++) begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    send_word(OP_SPARE_5 + OPCODE_W'($urandom_range(0, 2)),
                              LETTER_W'($urandom_range(0, 31)));
                else if (pick == 1)
                    send_word(OP_KEY_LETTER, rand_letter());
                else if (pick == 2)
                    send_word(OP_KEY_DONE, LETTER_W'($urandom_range(0, 31)));
                else if (pick <= 4)
                    send_word(OP_END_MSG, LETTER_W'($urandom_range(0, 31)));
                else begin
                    // letters 5..9 repeat the last one to hit doubled pairs
                    if (pick > 9) last_ltr = rand_letter();
                    send_word(OP_PLAIN, last_ltr);
                end
            end
            if ($urandom_range(0, 1) == 0) send_word(OP_END_MSG, LETTER_W'($urandom_range(0, 31)));
            phase_no++;
        end
        in_ch.valid <= 1'b0;

        // drain
        while (expect_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
